// ----- design/png_scanline_unfilter_16bit_gray_core_defines.svh -----
// Assertion macros used by the scanline unfilter control module
`ifndef PNG_SCANLINE_UNFILTER_16BIT_GRAY_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_16BIT_GRAY_CORE_DEFINES_SVH
`ifndef SYNTH
`define PNGU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PNGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PNGU_ASSERT(lbl, clk, rstn, prop, msg)
`define PNGU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/pngu_pkg.sv -----
// Types and constants for the PNG scanline unfilter
package pngu_pkg;

    localparam int MAX_ROW_BYTES_DEF = 4096;
    localparam int ROW_BYTES_W       = 13;
    localparam int BYTES_PER_PIXEL   = 2;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 13'd1280;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4,
        FILT_PASS  = 3'd5
    } filt_t;

    // Control that travels with an item from the input stage to reconstruction
    typedef struct packed {
        logic  pixel;
        filt_t filt;
        logic  first;
        logic  err;
        logic  last;
    } item_ctrl_t;

endpackage

// ----- design/pngu_if.sv -----
// Channel interfaces: input bytes, output bytes and row length writes
interface pngu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface pngu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       filter_error;

    modport source (output valid, output pixel_byte, output row_last, output filter_error,
                    input ready);
    modport sink (input valid, input pixel_byte, input row_last, input filter_error,
                  output ready);
endinterface

interface pngu_cfg_if;
    import pngu_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [ROW_BYTES_W-1:0] row_bytes;

    modport source (output valid, output row_bytes, input ready);
    modport sink (input valid, input row_bytes, output ready);
endinterface

// ----- design/pngu_line_store.sv -----
// Prior row line store: one write port, one registered read port
module pngu_line_store #(
    parameter int DEPTH  = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int ADDR_W = $clog2(pngu_pkg::MAX_ROW_BYTES_DEF)
) (
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read data while no new read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pngu_ctrl.sv -----
// Row sequencing, filter decode and input register
`include "png_scanline_unfilter_16bit_gray_core_defines.svh"
module pngu_ctrl #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    pngu_in_if.sink                              bytes_in,
    pngu_cfg_if.sink                             cfg,
    output logic                                 re,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]     raddr,
    output logic                                 b_valid,
    output pngu_pkg::item_ctrl_t                 b_ctrl,
    output logic [7:0]                           b_data,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]     b_idx,
    input  logic                                 b_take
);
    import pngu_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int CMP_W  = (POS_W > ROW_BYTES_W) ? POS_W : ROW_BYTES_W;

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [POS_W-1:0]       pos_reg, pos_next;
    filt_t                  filt_reg, filt_next;
    logic                   first_reg, first_next;
    logic                   err_reg, err_next;

    logic                   b_valid_reg, b_valid_next;
    item_ctrl_t             b_ctrl_reg, b_ctrl_next;
    logic [7:0]             b_data_reg;
    logic [ADDR_W-1:0]      b_idx_reg;

    logic                   acc;
    logic [POS_W-1:0]       pos_cur, pos_m1;
    logic                   first_cur, err_cur, is_filter, bad, last;
    logic [CMP_W-1:0]       rb_ext, rb_eff, pos_ext;

    assign bytes_in.ready = !b_valid_reg || b_take;
    assign cfg.ready      = 1'b1;
    assign acc            = bytes_in.valid && bytes_in.ready;

    always_comb
    begin
        // Effective row length, clamped to the line store
        rb_ext = CMP_W'(row_bytes_reg);
        if (rb_ext < CMP_W'(2))
        begin
            rb_eff = CMP_W'(2);
        end
        else if (rb_ext > CMP_W'(MAX_ROW_BYTES))
        begin
            rb_eff = CMP_W'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = rb_ext;
        end

        // A frame start always opens a new row
        pos_cur   = bytes_in.frame_start ? '0 : pos_reg;
        first_cur = bytes_in.frame_start | first_reg;
        err_cur   = !bytes_in.frame_start & err_reg;
        is_filter = (pos_cur == '0);
        bad       = (bytes_in.data_byte > 8'(FILT_PAETH));
        pos_m1    = pos_cur - POS_W'(1);
        pos_ext   = CMP_W'(pos_cur);
        last      = !is_filter && (pos_ext >= rb_eff);

        pos_next   = pos_reg;
        filt_next  = filt_reg;
        first_next = first_reg;
        err_next   = err_reg;
        if (acc)
        begin
            if (is_filter)
            begin
                filt_next  = bad ? FILT_PASS : filt_t'(bytes_in.data_byte[2:0]);
                err_next   = err_cur | bad;
                first_next = first_cur;
                pos_next   = POS_W'(1);
            end
            else
            begin
                pos_next   = last ? '0 : pos_cur + POS_W'(1);
                first_next = last ? 1'b0 : first_cur;
                err_next   = err_cur;
            end
        end

        b_ctrl_next.pixel = !is_filter;
        b_ctrl_next.filt  = filt_reg;
        b_ctrl_next.first = first_cur;
        b_ctrl_next.err   = err_next;
        b_ctrl_next.last  = last;

        b_valid_next = acc ? 1'b1 : (b_take ? 1'b0 : b_valid_reg);
    end

    assign re    = acc && !is_filter;
    assign raddr = pos_m1[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RST;
            pos_reg       <= '0;
            filt_reg      <= FILT_NONE;
            first_reg     <= 1'b1;
            err_reg       <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                row_bytes_reg <= cfg.row_bytes;
            end
            pos_reg     <= pos_next;
            filt_reg    <= filt_next;
            first_reg   <= first_next;
            err_reg     <= err_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            b_ctrl_reg <= b_ctrl_next;
            b_data_reg <= bytes_in.data_byte;
            b_idx_reg  <= pos_m1[ADDR_W-1:0];
        end
    end

    assign b_valid = b_valid_reg;
    assign b_ctrl  = b_ctrl_reg;
    assign b_data  = b_data_reg;
    assign b_idx   = b_idx_reg;

    `PNGU_ASSERT_NEXT(a_filter_opens_row, clk, rst_n, acc && is_filter, pos_reg == POS_W'(1), "filter byte did not open the row")
    `PNGU_ASSERT(a_err_sticky, clk, rst_n, !$fell(err_reg) || $past(acc && bytes_in.frame_start), "error flag cleared without frame start")
    `PNGU_ASSERT_NEXT(a_stage_hold, clk, rst_n, b_valid_reg && !b_take, b_valid_reg && $stable(b_data_reg), "held item lost")
    `PNGU_ASSERT(a_pos_bound, clk, rst_n, CMP_W'(pos_reg) <= CMP_W'(MAX_ROW_BYTES), "row position beyond line store")

endmodule

// ----- design/pngu_recon.sv -----
// Byte reconstruction against left, upper and upper-left neighbours; output register
module pngu_recon #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             b_valid,
    input  pngu_pkg::item_ctrl_t             b_ctrl,
    input  logic [7:0]                       b_data,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0] b_idx,
    input  logic [7:0]                       prior_byte,
    output logic                             b_take,
    output logic                             we,
    output logic [$clog2(MAX_ROW_BYTES)-1:0] waddr,
    output logic [7:0]                       wdata,
    pngu_out_if.source                       bytes_out
);
    import pngu_pkg::*;

    logic [7:0] left_reg [BYTES_PER_PIXEL];
    logic [7:0] ul_reg [BYTES_PER_PIXEL];
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_err_reg;

    logic [7:0] a, b, c, pred, val;
    logic [8:0] sum_ab;
    logic [7:0] pa, pb;
    logic [8:0] pc, s2c;
    logic       load;

    always_comb
    begin
        a      = left_reg[BYTES_PER_PIXEL-1];
        b      = b_ctrl.first ? 8'd0 : prior_byte;
        c      = ul_reg[BYTES_PER_PIXEL-1];
        sum_ab = {1'b0, a} + {1'b0, b};
        s2c    = {c, 1'b0};
        pa     = (b > c) ? b - c : c - b;
        pb     = (a > c) ? a - c : c - a;
        pc     = (sum_ab > s2c) ? sum_ab - s2c : s2c - sum_ab;

        unique case (b_ctrl.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum_ab[8:1];
            FILT_PAETH:
            begin
                // Pick the neighbour nearest to a + b - c, ties to left then upper
                if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc))
                begin
                    pred = a;
                end
                else if ({1'b0, pb} <= pc)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 8'd0;
        endcase
        val = b_data + pred;
    end

    assign b_take = b_valid && (!b_ctrl.pixel || !out_valid_reg || bytes_out.ready);
    assign load   = b_take && b_ctrl.pixel;
    assign we     = load;
    assign waddr  = b_idx;
    assign wdata  = val;

    always_comb
    begin
        out_valid_next = out_valid_reg && !bytes_out.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BYTES_PER_PIXEL; i++)
            begin
                left_reg[i] <= 8'd0;
                ul_reg[i]   <= 8'd0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                left_reg[0] <= val;
                ul_reg[0]   <= b;
                for (int i = 1; i < BYTES_PER_PIXEL; i++)
                begin
                    left_reg[i] <= left_reg[i-1];
                    ul_reg[i]   <= ul_reg[i-1];
                end
            end
            else if (b_take)
            begin
                // Filter byte: drop the neighbours of the previous row
                for (int i = 0; i < BYTES_PER_PIXEL; i++)
                begin
                    left_reg[i] <= 8'd0;
                    ul_reg[i]   <= 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= val;
            out_last_reg <= b_ctrl.last;
            out_err_reg  <= b_ctrl.err;
        end
    end

    assign bytes_out.valid        = out_valid_reg;
    assign bytes_out.pixel_byte   = out_byte_reg;
    assign bytes_out.row_last     = out_last_reg;
    assign bytes_out.filter_error = out_err_reg;

endmodule

// ----- design/png_scanline_unfilter_16bit_gray_core.sv -----
// Top level of the PNG scanline unfilter for 16-bit greyscale
//
//   channel    dir   payload                                  accepted when
//   bytes_in   in    data_byte[7:0], frame_start              valid && ready
//   bytes_out  out   pixel_byte[7:0], row_last, filter_error  valid && ready
//   cfg        in    row_bytes[12:0]                          valid && ready
//
// One item a cycle sustained while bytes_out is ready; a pixel byte taken from bytes_in
// first sits in the input register while the line store read completes, then it waits
// in the output register to be offered on bytes_out. A filter byte gives no item.
// The line store's single registered read port sets the two-stage depth.
// rst_n clears the sequencing state; the line store needs no clearing pass.
// bytes_in stays ready while the output register drains in the same cycle.
module png_scanline_unfilter_16bit_gray_core #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pngu_in_if.sink      bytes_in,
    pngu_out_if.source   bytes_out,
    pngu_cfg_if.sink     cfg
);
    import pngu_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

    logic              re, we, b_valid, b_take;
    logic [ADDR_W-1:0] raddr, waddr, b_idx;
    logic [7:0]        rdata, wdata, b_data;
    item_ctrl_t        b_ctrl;

    pngu_ctrl #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes_in (bytes_in),
        .cfg      (cfg),
        .re       (re),
        .raddr    (raddr),
        .b_valid  (b_valid),
        .b_ctrl   (b_ctrl),
        .b_data   (b_data),
        .b_idx    (b_idx),
        .b_take   (b_take)
    );

    pngu_line_store #(
        .DEPTH  (MAX_ROW_BYTES),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk   (clk),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata)
    );

    pngu_recon #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_recon (
        .clk        (clk),
        .rst_n      (rst_n),
        .b_valid    (b_valid),
        .b_ctrl     (b_ctrl),
        .b_data     (b_data),
        .b_idx      (b_idx),
        .prior_byte (rdata),
        .b_take     (b_take),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .bytes_out  (bytes_out)
    );

endmodule
